// ===== rtl/core/tks_pkg.sv =====
// Shared types and constants for the streaming top-k selector.
`default_nettype none
package tks_pkg;

	localparam int K_MAX_DEF = 16;
	localparam int N_MAX_DEF = 65536;

	localparam int VAL_W   = 32;
	localparam int POS_W   = 16;
	localparam int KCFG_W  = 5;

	localparam logic [KCFG_W-1:0] K_COUNT_RST = KCFG_W'(1);

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             last_in;
	} tks_in_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] top_value;
		logic             last_out;
	} tks_out_t;

endpackage
`default_nettype wire

// ===== rtl/core/tks_insert.sv =====
// Sorted list of kept entries with parallel compare-and-shift insertion.
`default_nettype none
module tks_insert
	import tks_pkg::*;
#(
	parameter int K_MAX = K_MAX_DEF,
	parameter int N_MAX = N_MAX_DEF,
	localparam int KW = $clog2(K_MAX + 1),
	localparam int PW = (N_MAX > 1) ? $clog2(N_MAX) : 1,
	localparam int NW = $clog2(N_MAX + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic [VAL_W-1:0]  value,
	input  wire logic              last_in,
	input  wire logic [KCFG_W-1:0] k_count,
	output logic      [VAL_W-1:0]  nxt_val [K_MAX],
	output logic      [PW-1:0]     nxt_pos [K_MAX],
	output logic      [KW-1:0]     nxt_cnt
);

	localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

	logic [VAL_W-1:0] kv_q [K_MAX];
	logic [PW-1:0]    kp_q [K_MAX];
	logic [KW-1:0]    cnt_q;
	logic [NW-1:0]    npos_q;

	logic [KW-1:0]    keff;
	logic [KW-1:0]    kc;
	logic [K_MAX-1:0] ge;
	logic             in_range;
	logic             full;
	logic [IW-1:0]    last_idx;
	logic             last_ge;
	logic             ins_ok;
	logic [PW-1:0]    cur_pos;

	always_comb begin
		if (int'(k_count) > K_MAX) begin
			keff = KW'(K_MAX);
		end else begin
			keff = KW'(k_count);
		end
		// A lowered k_count cuts the list before this item is placed.
		kc = (cnt_q > keff) ? keff : cnt_q;
		in_range = npos_q < NW'(N_MAX);
		cur_pos = PW'(npos_q);
		full = (kc == keff);
		last_idx = IW'(kc - KW'(1));
		last_ge = (kc == '0) ? 1'b1 : ge[last_idx];
		ins_ok = in_range && (keff != '0) && (!full || !last_ge);
		if (!ins_ok) begin
			nxt_cnt = kc;
		end else if (full) begin
			nxt_cnt = kc;
		end else begin
			nxt_cnt = kc + KW'(1);
		end
	end

	for (genvar i = 0; i < K_MAX; i++) begin : g_cell
		// Equal values stay ahead of the new one, so ties favor the earlier position.
		assign ge[i] = (KW'(i) < kc) && (kv_q[i] >= value);

		if (i == 0) begin : g_head
			always_comb begin
				if (!ins_ok || ge[i]) begin
					nxt_val[i] = kv_q[i];
					nxt_pos[i] = kp_q[i];
				end else begin
					nxt_val[i] = value;
					nxt_pos[i] = cur_pos;
				end
			end
		end else begin : g_body
			always_comb begin
				if (!ins_ok || ge[i]) begin
					nxt_val[i] = kv_q[i];
					nxt_pos[i] = kp_q[i];
				end else if (ge[i-1]) begin
					nxt_val[i] = value;
					nxt_pos[i] = cur_pos;
				end else begin
					nxt_val[i] = kv_q[i-1];
					nxt_pos[i] = kp_q[i-1];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				kv_q[i] <= nxt_val[i];
				kp_q[i] <= nxt_pos[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			npos_q <= '0;
		end else if (advance) begin
			if (last_in) begin
				cnt_q  <= '0;
				npos_q <= '0;
			end else begin
				cnt_q <= nxt_cnt;
				if (in_range) begin
					npos_q <= npos_q + NW'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/tks_drain.sv =====
// Result buffer that sends a finished list through an output register, one item per cycle unless out_stall holds it.
`default_nettype none
module tks_drain
	import tks_pkg::*;
#(
	parameter int K_MAX = K_MAX_DEF,
	parameter int N_MAX = N_MAX_DEF,
	localparam int KW = $clog2(K_MAX + 1),
	localparam int PW = (N_MAX > 1) ? $clog2(N_MAX) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic [KW-1:0]    load_cnt,
	input  wire logic [VAL_W-1:0] load_val [K_MAX],
	input  wire logic [PW-1:0]    load_pos [K_MAX],
	output logic                  busy,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output tks_out_t              out_item
);

	logic [VAL_W-1:0]    dv_q [K_MAX];
	logic [PW-1:0]       dp_q [K_MAX];
	logic [KW-1:0]       dcnt_q;
	logic                out_valid_q;
	tks_out_t            out_item_q;
	logic                pop;
	logic [PW+POS_W-1:0] pos_ext;

	assign busy = (dcnt_q != '0);
	assign pop  = busy && (!out_valid_q || !out_stall);
	assign pos_ext = {{POS_W{1'b0}}, dp_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				dcnt_q <= load_cnt;
			end else if (pop) begin
				dcnt_q <= dcnt_q - KW'(1);
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Entry zero is always the next one out; each pop moves the rest up.
	always_ff @(posedge clk) begin
		if (load) begin
			dv_q <= load_val;
			dp_q <= load_pos;
		end else if (pop) begin
			for (int i = 0; i < K_MAX - 1; i++) begin
				dv_q[i] <= dv_q[i+1];
				dp_q[i] <= dp_q[i+1];
			end
		end
		if (pop) begin
			out_item_q.position  <= pos_ext[POS_W-1:0];
			out_item_q.top_value <= dv_q[0];
			out_item_q.last_out  <= (dcnt_q == KW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
`default_nettype wire

// ===== rtl/core/streaming_top_k_selector_unit.sv =====
// An item is registered in the input register, then placed in the sorted list when it advances.
// Results of a vector load into the result buffer as its last item advances, then leave one per cycle unless stalled.
// Throughput: one item per cycle; a last item waits in the input register until
// the previous vector's results have all left the result buffer.
// Reset: arst_n clears the list count, position counter, k_count (to 1) and all valids.
`default_nettype none
module streaming_top_k_selector_unit
	import tks_pkg::*;
#(
	parameter int K_MAX = K_MAX_DEF,
	parameter int N_MAX = N_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire tks_in_t           in_item,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output tks_out_t               out_item,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [KCFG_W-1:0] cfg_data
);

	localparam int KW = $clog2(K_MAX + 1);
	localparam int PW = (N_MAX > 1) ? $clog2(N_MAX) : 1;

	logic              s1_valid;
	logic [VAL_W-1:0]  value_s1;
	logic              last_s1;
	logic [KCFG_W-1:0] k_count_q;
	logic              advance;
	logic              drain_busy;
	logic [VAL_W-1:0]  nxt_val [K_MAX];
	logic [PW-1:0]     nxt_pos [K_MAX];
	logic [KW-1:0]     nxt_cnt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_count_q <= K_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			k_count_q <= cfg_data;
		end
	end

	// A last item holds until the result buffer is free for its list.
	assign advance  = s1_valid && !(last_s1 && drain_busy);
	assign in_stall = s1_valid && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			value_s1 <= in_item.value;
			last_s1  <= in_item.last_in;
		end
	end

	tks_insert #(
		.K_MAX(K_MAX),
		.N_MAX(N_MAX)
	) u_insert (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.value   (value_s1),
		.last_in (last_s1),
		.k_count (k_count_q),
		.nxt_val (nxt_val),
		.nxt_pos (nxt_pos),
		.nxt_cnt (nxt_cnt)
	);

	tks_drain #(
		.K_MAX(K_MAX),
		.N_MAX(N_MAX)
	) u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && last_s1),
		.load_cnt  (nxt_cnt),
		.load_val  (nxt_val),
		.load_pos  (nxt_pos),
		.busy      (drain_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire
